@@ src/triangle_scanline_span_generator_core_assert.svh @@
// Assertion macros for the span generator.
`ifndef TRIANGLE_SCANLINE_SPAN_GENERATOR_CORE_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TSG_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define TSG_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define TSG_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define TSG_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

@@ src/tsg_pkg.sv @@
// Package: types, constants and state codes of the span generator.
`timescale 1ns / 1ps
`default_nettype none
package tsg_pkg;
    localparam int COORD_WIDTH_DEF    = 16;
    localparam int SCREEN_DIM_MAX_DEF = 4096;
    localparam int CFG_WIDTH          = 13;
    localparam int CFG_IDX_WIDTH      = 1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SCREEN_HEIGHT = 1'b1;
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;
    // Width of the dividend/quotient in the edge divider.
    localparam int DIV_WIDTH = 40;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic               action;
        logic signed [15:0] vertex_a_x;
        logic signed [15:0] vertex_a_y;
        logic signed [15:0] vertex_b_x;
        logic signed [15:0] vertex_b_y;
        logic signed [15:0] vertex_c_x;
        logic signed [15:0] vertex_c_y;
        logic [31:0]        fill_colour_in;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] row;
        logic [11:0]        x_start;
        logic [11:0]        x_end;
        logic [31:0]        span_colour;
        logic               span_valid;
        logic               last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_A,
        ST_DIV_B,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic idle_emit;
        logic setup;
        logic start_a;
        logic start_b;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic flat;
        logic active;
        logic row_ok;
        logic div_done;
    } t_status;
endpackage
`default_nettype wire

@@ src/tsg_divider.sv @@
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module tsg_divider import tsg_pkg::*; (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire signed [DIV_WIDTH-1:0]  i_num,
    input  wire [DIV_WIDTH-1:0]         i_den,
    output logic                        o_done,
    output logic signed [DIV_WIDTH-1:0] o_quot
);
    logic [DIV_WIDTH-1:0] r_rem, n_rem, r_q, n_q, r_den;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy, r_neg, r_done, n_done;
    logic [DIV_WIDTH:0]   w_trial;

    // Shift in one numerator bit and try subtraction.
    always_comb begin
        w_trial = {r_rem, r_q[DIV_WIDTH-1]} - {1'b0, r_den};
        n_rem = r_rem; n_q = r_q; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_rem = '0;
            n_q = i_num[DIV_WIDTH-1] ? -i_num : i_num;
            n_cnt = DIV_CNT_W'(DIV_WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[DIV_WIDTH]) begin
                n_rem = w_trial[DIV_WIDTH-1:0];
                n_q = {r_q[DIV_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[DIV_WIDTH-2:0], r_q[DIV_WIDTH-1]};
                n_q = {r_q[DIV_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_rem <= n_rem; r_q <= n_q;
        if (i_start) begin
            r_den <= i_den;
            r_neg <= i_num[DIV_WIDTH-1];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

@@ src/tsg_datapath.sv @@
// Datapath: vertex sort, edge setup, span clamp and result register.
`timescale 1ns / 1ps
`default_nettype none
module tsg_datapath import tsg_pkg::*; #(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int SCREEN_DIM_MAX = SCREEN_DIM_MAX_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  t_in_item                   i_item,
    input  wire                        i_cfg_we,
    input  wire [CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  wire [CFG_WIDTH-1:0]        i_cfg_data,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    output t_out_item                  o_result
);
    localparam int CW = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
    localparam int LIM = (SCREEN_DIM_MAX < 4096) ? SCREEN_DIM_MAX : 4096;

    logic [CFG_WIDTH-1:0] r_width, r_height;
    logic signed [16:0] r_sx [3];
    logic signed [16:0] r_sy [3];
    logic [31:0]        r_colour;
    logic signed [16:0] r_row;
    logic               r_active;
    logic               r_seg_ok, r_last, r_onscr;
    logic signed [DIV_WIDTH-1:0] r_xa;
    logic signed [DIV_WIDTH-1:0] r_num_a, r_num_b;
    logic [DIV_WIDTH-1:0] r_den_a, r_den_b;
    t_out_item r_res;

    function automatic logic signed [16:0] coord(input logic [15:0] v);
        logic [15:0] t;
        t = v << (16 - CW);
        return 17'(signed'(t) >>> (16 - CW));
    endfunction

    // Sort with three strict compare-swaps.
    logic signed [16:0] s0x, s0y, s1x, s1y, s2x, s2y, tx, ty;
    always_comb begin
        s0x = coord(i_item.vertex_a_x); s0y = coord(i_item.vertex_a_y);
        s1x = coord(i_item.vertex_b_x); s1y = coord(i_item.vertex_b_y);
        s2x = coord(i_item.vertex_c_x); s2y = coord(i_item.vertex_c_y);
        if (s0y > s1y) begin tx = s0x; ty = s0y; s0x = s1x; s0y = s1y; s1x = tx; s1y = ty; end
        else begin tx = '0; ty = '0; end
        if (s0y > s2y) begin tx = s0x; ty = s0y; s0x = s2x; s0y = s2y; s2x = tx; s2y = ty; end
        if (s1y > s2y) begin tx = s1x; ty = s1y; s1x = s2x; s1y = s2y; s2x = tx; s2y = ty; end
    end

    // Effective screen limits.
    logic [CFG_WIDTH-1:0] w_eff, h_eff;
    assign w_eff = (r_width  > CFG_WIDTH'(LIM)) ? CFG_WIDTH'(LIM) : r_width;
    assign h_eff = (r_height > CFG_WIDTH'(LIM)) ? CFG_WIDTH'(LIM) : r_height;

    // Row setup values.
    logic signed [17:0] w_t0, w_t1, w_total, w_seg, w_dx02, w_dx01, w_dx12;
    logic               w_lower;
    assign w_lower = (r_row > r_sy[1]) || (r_sy[1] == r_sy[0]);
    assign w_t0    = 18'(r_row) - 18'(r_sy[0]);
    assign w_t1    = 18'(r_row) - 18'(r_sy[1]);
    assign w_total = 18'(r_sy[2]) - 18'(r_sy[0]);
    assign w_seg   = w_lower ? 18'(r_sy[2]) - 18'(r_sy[1]) : 18'(r_sy[1]) - 18'(r_sy[0]);
    assign w_dx02  = 18'(r_sx[2]) - 18'(r_sx[0]);
    assign w_dx01  = 18'(r_sx[1]) - 18'(r_sx[0]);
    assign w_dx12  = 18'(r_sx[2]) - 18'(r_sx[1]);

    // Numerators: from*h + d*t, products registered next.
    logic signed [DIV_WIDTH-1:0] w_na, w_nb;
    assign w_na = DIV_WIDTH'(r_sx[0] * w_total) + DIV_WIDTH'(w_dx02 * w_t0);
    assign w_nb = w_lower ? DIV_WIDTH'(r_sx[1] * w_seg) + DIV_WIDTH'(w_dx12 * w_t1)
                          : DIV_WIDTH'(r_sx[0] * w_seg) + DIV_WIDTH'(w_dx01 * w_t0);

    logic div_start, div_done;
    logic signed [DIV_WIDTH-1:0] div_num, div_quot;
    logic [DIV_WIDTH-1:0] div_den;
    assign div_start = i_cmd.start_a | i_cmd.start_b;
    assign div_num   = i_cmd.start_a ? r_num_a : r_num_b;
    assign div_den   = i_cmd.start_a ? r_den_a : r_den_b;

    tsg_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quot(div_quot)
    );

    // Order and clamp ends.
    logic signed [DIV_WIDTH-1:0] f_lo, f_hi;
    logic f_ok;
    always_comb begin
        f_lo = (r_xa > div_quot) ? div_quot : r_xa;
        f_hi = (r_xa > div_quot) ? r_xa : div_quot;
        if (f_lo < 0) f_lo = '0;
        if (f_hi >= $signed({{(DIV_WIDTH-CFG_WIDTH){1'b0}}, w_eff}))
            f_hi = $signed({{(DIV_WIDTH-CFG_WIDTH){1'b0}}, w_eff}) - 1;
        f_ok = (f_lo <= f_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= CFG_WIDTH'(640); r_height <= CFG_WIDTH'(480);
            for (int i = 0; i < 3; i++) begin r_sx[i] <= '0; r_sy[i] <= '0; end
            r_colour <= '0; r_row <= '0; r_active <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_SCREEN_WIDTH)  r_width  <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == REG_SCREEN_HEIGHT) r_height <= i_cfg_data;
            if (i_cmd.load) begin
                r_sx[0] <= s0x; r_sy[0] <= s0y; r_sx[1] <= s1x; r_sy[1] <= s1y;
                r_sx[2] <= s2x; r_sy[2] <= s2y;
                r_colour <= i_item.fill_colour_in;
                r_row <= s0y;
                r_active <= (s2y != s0y);
            end
            if (i_cmd.finish) begin
                if (r_last) r_active <= 1'b0;
                else r_row <= r_row + 17'sd1;
            end
        end
        if (i_cmd.setup) begin
            r_num_a <= w_na; r_den_a <= DIV_WIDTH'(w_total);
            r_num_b <= w_nb; r_den_b <= DIV_WIDTH'(w_seg);
            r_seg_ok <= (w_seg > 0);
            r_last <= (r_row >= r_sy[2]);
            r_onscr <= (r_row >= 0) && (r_row < $signed({5'b0, h_eff}));
        end
        if (i_cmd.start_b) r_xa <= div_quot;
        // Result register.
        if (i_cmd.load) begin
            r_res <= '{row: s0y[15:0], x_start: '0, x_end: '0,
                       span_colour: i_item.fill_colour_in, span_valid: 1'b0, last: 1'b1};
        end else if (i_cmd.idle_emit) begin
            r_res <= '{row: r_row[15:0], x_start: '0, x_end: '0,
                       span_colour: r_colour, span_valid: 1'b0, last: 1'b1};
        end else if (i_cmd.finish) begin
            r_res.row <= r_row[15:0];
            r_res.span_colour <= r_colour;
            r_res.last <= r_last;
            r_res.span_valid <= r_onscr && r_seg_ok && f_ok;
            r_res.x_start <= (r_onscr && r_seg_ok && f_ok) ? f_lo[11:0] : '0;
            r_res.x_end   <= (r_onscr && r_seg_ok && f_ok) ? f_hi[11:0] : '0;
        end
    end

    assign o_status = '{flat: (s2y == s0y), active: r_active,
                        row_ok: r_onscr && r_seg_ok, div_done: div_done};
    assign o_result = r_res;
endmodule
`default_nettype wire

@@ src/tsg_controller.sv @@
// Controller: sequences load, setup, two divisions and result handoff.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_scanline_span_generator_core_assert.svh"
module tsg_controller import tsg_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    input  wire     i_action,
    output logic    o_out_valid,
    input  wire     i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   w_acc;
    assign w_acc = i_in_valid && o_in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_acc) begin
                if (i_action == ACT_LOAD) n_state = i_status.flat ? ST_OUT : ST_IDLE;
                else n_state = i_status.active ? ST_SETUP : ST_OUT;
            end
            ST_SETUP:  n_state = i_status.row_ok ? ST_DIV_A : ST_DIV_A;
            ST_DIV_A:  if (i_status.div_done) n_state = ST_DIV_B;
            ST_DIV_B:  if (i_status.div_done) n_state = ST_FINISH;
            ST_FINISH: n_state = ST_OUT;
            ST_OUT:    if (i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    logic r_first;
    always_comb begin
        o_cmd = '0;
        o_in_ready = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        o_cmd.load = w_acc && (i_action == ACT_LOAD);
        o_cmd.idle_emit = w_acc && (i_action == ACT_STEP) && !i_status.active;
        o_cmd.setup = (r_state == ST_SETUP);
        o_cmd.start_a = r_first;
        o_cmd.start_b = (r_state == ST_DIV_A) && i_status.div_done;
        o_cmd.finish = (r_state == ST_DIV_B) && i_status.div_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_first <= 1'b0;
        end else begin
            r_state <= n_state; r_first <= (r_state == ST_SETUP);
        end
    end

    `TSG_ASSERT_IMP(a_out_only_idle_accept, i_clk, i_rst_n, o_out_valid, !o_in_ready, "accept during output")
    `TSG_ASSERT_NEXT(a_setup_then_div, i_clk, i_rst_n, r_state == ST_SETUP, r_state == ST_DIV_A, "setup order")
    `TSG_ASSERT_IMP(a_one_start, i_clk, i_rst_n, o_cmd.start_a, !o_cmd.start_b, "double divider start")
endmodule
`default_nettype wire

@@ src/triangle_scanline_span_generator_core.sv @@
// Top level of the triangle scanline span generator.
`timescale 1ns / 1ps
`default_nettype none
// Takes load and step items one at a time. A load of a flat triangle yields
// one result. A step on an active triangle runs a setup state, then two
// 40-bit divisions on one shared radix-2 divider (the second started in the
// cycle the first ends); the clamped span is then registered and passes the
// finish state to the output state, where it is held in the output register
// until taken. Idle steps yield one result each.
module triangle_scanline_span_generator_core import tsg_pkg::*; #(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int SCREEN_DIM_MAX = SCREEN_DIM_MAX_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_item,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output t_out_item               o_out_item,
    input  wire                     i_cfg_we,
    input  wire [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  wire [CFG_WIDTH-1:0]     i_cfg_data
);
    t_cmd    w_cmd;
    t_status w_status;

    tsg_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_action(i_in_item.action),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    tsg_datapath #(.COORD_WIDTH(COORD_WIDTH), .SCREEN_DIM_MAX(SCREEN_DIM_MAX)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_in_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_cmd(w_cmd), .o_status(w_status), .o_result(o_out_item)
    );
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for the triangle scanline span generator: directed shapes, then random triangles.
`timescale 1ns / 1ps
module tb_top;
    import tsg_pkg::*;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     in_valid;
    logic                     in_ready;
    t_in_item                 in_item;
    logic                     out_valid;
    logic                     out_ready;
    t_out_item                out_item;
    logic                     cfg_we;
    logic [CFG_IDX_WIDTH-1:0] cfg_idx;
    logic [CFG_WIDTH-1:0]     cfg_data;

    triangle_scanline_span_generator_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Shadow of the block state
    longint    vx [3];
    longint    vy [3];
    logic [31:0] colour_q;
    longint    row_q;
    bit        tri_active;
    int        width_reg;
    int        height_reg;

    t_out_item span_q [$];
    int        errors;
    int        items_sent;
    int        spans_seen;
    int        valid_spans;
    int        send_idle_pct;
    int        recv_stall_pct;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clamp_dim(int r);
        return (r > 4096) ? 4096 : r;
    endfunction

    // Swap two stored vertices when the upper one lies lower
    function automatic void order_pair(int i, int j);
        longint tx;
        longint ty;
        if (vy[i] > vy[j]) begin
            tx = vx[i]; ty = vy[i];
            vx[i] = vx[j]; vy[i] = vy[j];
            vx[j] = tx; vy[j] = ty;
        end
    endfunction

    function automatic t_out_item make_span(longint r, longint xs, longint xe, bit ok, bit lst);
        t_out_item o;
        o.row         = r[15:0];
        o.x_start     = ok ? xs[11:0] : 12'd0;
        o.x_end       = ok ? xe[11:0] : 12'd0;
        o.span_colour = colour_q;
        o.span_valid  = ok;
        o.last        = lst;
        return o;
    endfunction

    // Work out the span that an accepted item yields, if any
    function automatic void predict_span(t_in_item it);
        longint y, tot, seg, xa, xb, t, w, h;
        bit     lower, lst, ok;
        if (it.action == ACT_LOAD) begin
            vx[0] = longint'(it.vertex_a_x); vy[0] = longint'(it.vertex_a_y);
            vx[1] = longint'(it.vertex_b_x); vy[1] = longint'(it.vertex_b_y);
            vx[2] = longint'(it.vertex_c_x); vy[2] = longint'(it.vertex_c_y);
            colour_q = it.fill_colour_in;
            order_pair(0, 1);
            order_pair(0, 2);
            order_pair(1, 2);
            row_q = vy[0];
            tri_active = (vy[2] != vy[0]);
            if (!tri_active) span_q.push_back(make_span(row_q, 0, 0, 0, 1));
            return;
        end
        if (!tri_active) begin
            span_q.push_back(make_span(row_q, 0, 0, 0, 1));
            return;
        end
        y   = row_q;
        tot = vy[2] - vy[0];
        w   = longint'(clamp_dim(width_reg));
        h   = longint'(clamp_dim(height_reg));
        lst = (y >= vy[2]);
        ok  = 0;
        xa  = 0;
        xb  = 0;
        if (y >= 0 && y < h && tot > 0) begin
            lower = (y > vy[1]) || (vy[1] == vy[0]);
            seg   = lower ? (vy[2] - vy[1]) : (vy[1] - vy[0]);
            if (seg > 0) begin
                xa = (vx[0] * tot + (vx[2] - vx[0]) * (y - vy[0])) / tot;
                if (lower) xb = (vx[1] * seg + (vx[2] - vx[1]) * (y - vy[1])) / seg;
                else       xb = (vx[0] * seg + (vx[1] - vx[0]) * (y - vy[0])) / seg;
                if (xa > xb) begin
                    t = xa; xa = xb; xb = t;
                end
                if (xa < 0) xa = 0;
                if (xb >= w) xb = w - 1;
                ok = (xa <= xb);
            end
        end
        span_q.push_back(make_span(y, xa, xb, ok, lst));
        if (lst) tri_active = 0;
        else     row_q = y + 1;
    endfunction

    // Check each span against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && out_valid && out_ready) begin
            spans_seen++;
            if (span_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected span, actual %p", $realtime, out_item);
            end else begin
                e = span_q.pop_front();
                if (e.span_valid) valid_spans++;
                if (out_item.row !== e.row || out_item.x_start !== e.x_start ||
                    out_item.x_end !== e.x_end || out_item.span_colour !== e.span_colour ||
                    out_item.span_valid !== e.span_valid || out_item.last !== e.last) begin
                    errors++;
                    $display("%0t: span mismatch, expected %p, actual %p",
                             $realtime, e, out_item);
                end
            end
        end
    end

    // Receiver stalls
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hand one item to the block and predict on acceptance
    task automatic send_item(t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        predict_span(it);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (span_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Write a register once the block has gone quiet
    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, int val);
        drain();
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CFG_WIDTH-1:0];
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == REG_SCREEN_WIDTH) width_reg = val & 16'h1FFF;
        else                         height_reg = val & 16'h1FFF;
    endtask

    task automatic load_tri(int ax, int ay, int bx, int by, int cx, int cy, logic [31:0] col);
        t_in_item it;
        it.action = ACT_LOAD;
        it.vertex_a_x = ax[15:0]; it.vertex_a_y = ay[15:0];
        it.vertex_b_x = bx[15:0]; it.vertex_b_y = by[15:0];
        it.vertex_c_x = cx[15:0]; it.vertex_c_y = cy[15:0];
        it.fill_colour_in = col;
        send_item(it);
    endtask

    task automatic step_rows(int n);
        t_in_item it;
        it = '0;
        repeat (n) begin
            it.action = ACT_STEP;
            it.fill_colour_in = $urandom;
            it.vertex_a_x = 16'($urandom);
            send_item(it);
        end
    endtask

    // Steps before any load and flat triangles
    task automatic test_idle_and_flat();
        step_rows(2);
        load_tri(10, 5, 20, 5, 30, 5, 32'hFFFF_FFFF);
        step_rows(1);
        load_tri(-32768, 32767, 32767, 32767, 0, 32767, 32'h0);
    endtask

    // Ordinary shapes: flat top, flat bottom, clipped edges, off-screen rows
    task automatic test_shapes();
        load_tri(5, 0, 1, 4, 9, 8, 32'h1234_5678);
        step_rows(10);
        load_tri(0, 2, 12, 2, 6, 6, 32'hA5A5_A5A5);
        step_rows(5);
        load_tri(6, 6, 0, 2, 12, 6, 32'h5A5A_5A5A);
        step_rows(5);
        load_tri(-40, -3, 700, 1, 320, 3, 32'hDEAD_BEEF);
        step_rows(7);
        load_tri(100, 478, 50, 481, 200, 483, 32'hCAFE_F00D);
        step_rows(3);
    endtask

    // Coordinate extremes: a few rows each of two triangles spanning the whole x range
    task automatic test_extremes();
        load_tri(-32768, -32768, 32767, 0, 0, 32767, 32'h8000_0001);
        step_rows(2);
        load_tri(32767, -1, -32768, 0, 32767, 1, 32'h7FFF_FFFE);
        step_rows(3);
    endtask

    task automatic rand_item(output t_in_item it);
        it.action = 1'($urandom);
        it.vertex_a_x = 16'($urandom); it.vertex_a_y = 16'($urandom);
        it.vertex_b_x = 16'($urandom); it.vertex_b_y = 16'($urandom);
        it.vertex_c_x = 16'($urandom); it.vertex_c_y = 16'($urandom);
        it.fill_colour_in = $urandom;
    endtask

    // Mostly whole triangles near the screen, some wide-range ones and noise
    task automatic test_random(int n_items);
        int stop_at, kind, base, ht, wl, hl;
        t_in_item it;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind = rnd(0, 99);
            wl = clamp_dim(width_reg);
            hl = clamp_dim(height_reg);
            if (kind < 72) begin
                ht = (rnd(0, 9) == 0) ? 0 : rnd(1, 14);
                base = rnd(-8, hl + 4);
                load_tri(rnd(-30, wl + 30), base + rnd(0, ht), rnd(-30, wl + 30),
                         base + rnd(0, ht), rnd(-30, wl + 30), base + ht, $urandom);
                step_rows(ht + 1 + rnd(0, 1));
            end else if (kind < 84) begin
                rand_item(it);
                it.action = ACT_LOAD;
                send_item(it);
                step_rows(rnd(1, 4));
            end else begin
                rand_item(it);
                send_item(it);
            end
        end
    endtask

    task automatic set_screen(int w, int h);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
    endtask

    initial begin
        errors = 0; items_sent = 0; spans_seen = 0; valid_spans = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        for (int i = 0; i < 3; i++) begin
            vx[i] = 0; vy[i] = 0;
        end
        colour_q = '0; row_q = 0; tri_active = 0;
        width_reg = 640; height_reg = 480;
        in_valid = 1'b0; in_item = '0; out_ready = 1'b0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_and_flat();
        test_shapes();
        test_extremes();
        set_screen(1, 1);
        load_tri(0, 0, 3, 1, -2, 1, 32'h0F0F_0F0F);
        step_rows(3);
        set_screen(0, 8191);
        load_tri(0, 0, 3, 2, -2, 2, 32'h1111_2222);
        step_rows(3);

        // Random part over idling phases and screen sizes
        set_screen(64, 48);
        test_random(330);
        send_idle_pct = 88;
        set_screen(4096, 4096);
        test_random(330);
        send_idle_pct = 0; recv_stall_pct = 88;
        set_screen(rnd(1, 200), rnd(1, 120));
        test_random(330);
        send_idle_pct = 34; recv_stall_pct = 34;
        set_screen(8191, 20);
        test_random(200);
        send_idle_pct = 0; recv_stall_pct = 0;
        set_screen(640, 480);
        test_random(130);

        drain();
        $display("Sent %0d items over four idling phases and several screen sizes;",
                 items_sent);
        $display("checked %0d spans, %0d of them drawable.", spans_seen, valid_spans);
        if (errors == 0 && span_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
